### rtl/owrs_pkg.sv
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types, codes and helpers for the 1-Wire ROM search decision engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 3;
  localparam int ROM_W     = 64;
  localparam int POS_W     = 7;
  localparam int IDX_W     = 6;
  localparam int FAM_W     = 4;
  localparam int COUNT_W   = 8;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BITS  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ACK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PROGRESS  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENDED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_PRES   = 3'd4;

  // Search constants
  localparam logic [POS_W-1:0] ROM_BITS_END = 7'd65;
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
  localparam logic [POS_W-1:0] LAST_POS     = 7'd64;
  localparam int               FAMILY_BITS  = 8;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                presence;
    logic                conditional_mode;
    logic                id_bit;
    logic                complement_bit;
  } owrs_item_t;

  typedef struct packed {
    logic [ROM_W-1:0]   rom_shadow;
    logic [POS_W-1:0]   last_disc;
    logic [FAM_W-1:0]   last_fam_disc;
    logic               last_dev_seen;
    logic [COUNT_W-1:0] dev_count;
    logic [POS_W-1:0]   bit_pos;
    logic [POS_W-1:0]   last_zero_pos;
    logic               pass_active;
  } owrs_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                direction;
    logic                search_mode_out;
    logic [ROM_W-1:0]    rom_code;
    logic                last_device;
    logic [COUNT_W-1:0]  devices_found;
    logic [FAM_W-1:0]    family_discrepancy;
  } owrs_result_t;

  localparam owrs_state_t STATE_RESET = '{
    rom_shadow:    '0,
    last_disc:     '0,
    last_fam_disc: '0,
    last_dev_seen: 1'b0,
    dev_count:     '0,
    bit_pos:       7'd1,
    last_zero_pos: '0,
    pass_active:   1'b0
  };

  // Drop the search: forget progress but keep the shadow ROM code
  function automatic owrs_state_t end_search(owrs_state_t s);
    owrs_state_t r;
    r               = s;
    r.dev_count     = '0;
    r.last_disc     = '0;
    r.last_fam_disc = '0;
    r.last_dev_seen = 1'b0;
    r.pass_active   = 1'b0;
    return r;
  endfunction

endpackage

### rtl/owrs_if.sv
// ----------------------------------------------------------------------------
// owrs_if
// Valid/ready channels for search requests and search results.
// ----------------------------------------------------------------------------
interface owrs_in_if;
  logic                              valid;
  logic                              ready;
  logic [owrs_pkg::ACTION_W-1:0]     action;
  logic                              presence;
  logic                              conditional_mode;
  logic                              id_bit;
  logic                              complement_bit;

  modport source (output valid, action, presence, conditional_mode, id_bit,
                  complement_bit, input ready);
  modport sink   (input valid, action, presence, conditional_mode, id_bit,
                  complement_bit, output ready);
endinterface

interface owrs_out_if;
  logic                              valid;
  logic                              ready;
  logic [owrs_pkg::STATUS_W-1:0]     status;
  logic                              direction;
  logic                              search_mode_out;
  logic [owrs_pkg::ROM_W-1:0]        rom_code;
  logic                              last_device;
  logic [owrs_pkg::COUNT_W-1:0]      devices_found;
  logic [owrs_pkg::FAM_W-1:0]        family_discrepancy;

  modport source (output valid, status, direction, search_mode_out, rom_code,
                  last_device, devices_found, family_discrepancy, input ready);
  modport sink   (input valid, status, direction, search_mode_out, rom_code,
                  last_device, devices_found, family_discrepancy, output ready);
endinterface

### rtl/owrs_decide.sv
// ----------------------------------------------------------------------------
// owrs_decide
// Single-step decision logic: next search state and result for one item.
// ----------------------------------------------------------------------------
module owrs_decide (
  input  owrs_pkg::owrs_item_t   item_i,
  input  owrs_pkg::owrs_state_t  st_i,
  output owrs_pkg::owrs_state_t  st_o,
  output owrs_pkg::owrs_result_t res_o
);
  import owrs_pkg::*;

  logic [IDX_W-1:0] bit_idx;
  logic             shadow_bit;
  logic             disc_dir;
  logic             pair_differs;
  logic             dir;
  logic [POS_W-1:0] pos_inc;
  logic [ROM_W-1:0] rom_upd;

  // Pick the direction for the current position
  assign bit_idx      = st_i.bit_pos[IDX_W-1:0] - IDX_W'(1);
  assign shadow_bit   = st_i.rom_shadow[bit_idx];
  assign disc_dir     = (st_i.bit_pos < st_i.last_disc) ? shadow_bit
                                                        : (st_i.bit_pos == st_i.last_disc);
  assign pair_differs = item_i.id_bit ^ item_i.complement_bit;
  assign dir          = pair_differs ? item_i.id_bit : disc_dir;
  assign pos_inc      = st_i.bit_pos + POS_W'(1);

  // Write the chosen bit into the shadow code
  always_comb begin
    rom_upd          = st_i.rom_shadow;
    rom_upd[bit_idx] = dir;
  end

  // Advance the search state
  always_comb begin
    owrs_state_t s;
    s     = st_i;
    res_o = '0;
    unique case (item_i.action)
      ACT_CLEAR: begin
        s = STATE_RESET;
      end
      ACT_BEGIN: begin
        if (st_i.last_dev_seen) begin
          s            = end_search(st_i);
          res_o.status = ST_ENDED;
        end else if (!item_i.presence) begin
          s            = end_search(st_i);
          res_o.status = ST_NO_PRES;
        end else begin
          s.pass_active         = 1'b1;
          s.bit_pos             = POS_W'(1);
          s.last_zero_pos       = '0;
          res_o.search_mode_out = item_i.conditional_mode;
          res_o.status          = ST_PROGRESS;
        end
      end
      ACT_BITS: begin
        if (st_i.pass_active) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            s            = end_search(st_i);
            res_o.status = ST_ENDED;
          end else begin
            s.rom_shadow = rom_upd;
            // Record a discrepancy where we took the zero branch
            if (!pair_differs && !dir) begin
              s.last_zero_pos = st_i.bit_pos;
              if (st_i.bit_pos < FAMILY_LIMIT) begin
                s.last_fam_disc = st_i.bit_pos[FAM_W-1:0];
              end
            end
            s.bit_pos = pos_inc;
            if (pos_inc >= ROM_BITS_END) begin
              s.pass_active   = 1'b0;
              s.bit_pos       = POS_W'(1);
              s.last_disc     = s.last_zero_pos;
              s.last_dev_seen = (s.last_zero_pos == '0) ? 1'b1 : st_i.last_dev_seen;
              if (rom_upd[FAMILY_BITS-1:0] == '0) begin
                s            = end_search(s);
                res_o.status = ST_ENDED;
              end else begin
                s.dev_count    = st_i.dev_count + COUNT_W'(1);
                res_o.rom_code = rom_upd;
                res_o.status   = ST_FOUND;
              end
            end else begin
              res_o.direction = dir;
              res_o.status    = ST_PROGRESS;
            end
          end
        end
      end
      default: begin
      end
    endcase
    st_o                     = s;
    res_o.last_device        = s.last_dev_seen;
    res_o.devices_found      = s.dev_count;
    res_o.family_discrepancy = s.last_fam_disc;
  end

endmodule

### rtl/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire ROM search decision engine with registered input and result stages.
//
//   channel  dir  transaction
//   in_ch    in   one request: clear, begin pass, or id bit pair
//   out_ch   out  one result per request: status, direction, ROM code, counts
//
// A request accepted on in_ch waits in the request register, is decided into
// the result register, and is valid there until out_ch takes it.
// One request is taken per cycle while out_ch drains; the decide step is a
// single pass of logic between the request register and the result register.
// A stalled result holds out_ch and the request register; in_ch still takes
// one request while the request register is empty.
// rst_n is synchronous and active low; it returns the search to its start.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic           clk,
  input  logic           rst_n,
  owrs_in_if.sink        in_ch,
  owrs_out_if.source     out_ch
);
  import owrs_pkg::*;

  owrs_item_t   item_r, item_nxt;
  logic         item_vld_r, item_vld_nxt;
  owrs_state_t  st_r, st_nxt, st_dec;
  owrs_result_t res_r, res_nxt, res_dec;
  logic         out_vld_r, out_vld_nxt;
  logic         in_fire;
  logic         proc;

  owrs_decide u_decide (
    .item_i (item_r),
    .st_i   (st_r),
    .st_o   (st_dec),
    .res_o  (res_dec)
  );

  // Handshake control
  assign proc        = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || proc;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Capture the request
  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r;
    if (in_fire) begin
      item_nxt.action           = in_ch.action;
      item_nxt.presence         = in_ch.presence;
      item_nxt.conditional_mode = in_ch.conditional_mode;
      item_nxt.id_bit           = in_ch.id_bit;
      item_nxt.complement_bit   = in_ch.complement_bit;
      item_vld_nxt              = 1'b1;
    end else if (proc) begin
      item_vld_nxt = 1'b0;
    end
  end

  // Commit state and load the result
  always_comb begin
    st_nxt      = st_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (proc) begin
      st_nxt      = st_dec;
      res_nxt     = res_dec;
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= STATE_RESET;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      st_r       <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  // Drive the result channel
  assign out_ch.valid              = out_vld_r;
  assign out_ch.status             = res_r.status;
  assign out_ch.direction          = res_r.direction;
  assign out_ch.search_mode_out    = res_r.search_mode_out;
  assign out_ch.rom_code           = res_r.rom_code;
  assign out_ch.last_device        = res_r.last_device;
  assign out_ch.devices_found      = res_r.devices_found;
  assign out_ch.family_discrepancy = res_r.family_discrepancy;

  // A running pass always sits on a valid ROM position
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pass_active |-> (st_r.bit_pos != '0 && st_r.bit_pos <= LAST_POS))
    else $error("bit position out of range during pass");

  // A found device never has a zero family byte
  a_found_family: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status == ST_FOUND) |-> (res_r.rom_code[FAMILY_BITS-1:0] != '0))
    else $error("device reported with zero family byte");

  // Direction is only driven on an in-progress result
  a_dir_only_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status != ST_PROGRESS) |-> !res_r.direction)
    else $error("direction set outside a bit step");

  // A held request stays until the result stage frees up
  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !proc) |=> (item_vld_r && $stable(item_r)))
    else $error("pending request lost");

  // Family discrepancy stays within the family byte
  a_fam_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.last_fam_disc <= FAM_W'(FAMILY_BITS))
    else $error("family discrepancy out of range");

endmodule
